FILE: rtl/nrrd_pkg.sv
// nrrd_pkg: shared constants, register map, result codes and types for the
// receive ring deframer. No dependencies.
`timescale 1ns / 1ps

package nrrd_pkg;

    // Ring size default for the top-level parameter
    localparam int unsigned RING_BYTES_DEF = 65536;

    // Configuration port geometry
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MIN_LEN = 3'd0;
    localparam logic [2:0] REG_MAX_LEN = 3'd1;
    localparam logic [2:0] REG_ACCEPT  = 3'd2;
    localparam logic [2:0] REG_REJECT  = 3'd3;
    localparam logic [2:0] REG_BIAS    = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_MIN_LEN = 16'd64;
    localparam logic [15:0] RST_MAX_LEN = 16'd1518;
    localparam logic [15:0] RST_ACCEPT  = 16'd1;
    localparam logic [15:0] RST_REJECT  = 16'd62;
    localparam logic [15:0] RST_BIAS    = 16'd16;

    // Parser phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_BODY    = 2'd1;
    localparam logic [1:0] PH_CORRUPT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;
    localparam logic [1:0] KIND_CORRUPT = 2'd3;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] entry_status;
        logic [15:0] frame_length;
        logic [15:0] release_pointer;
    } t_result;

endpackage

FILE: rtl/nic_receive_ring_deframer_top.sv
// Receive ring deframer top level: header parse, payload pass-through,
// release pointer generation, APB register file and output skid stage.
// Depends on nrrd_pkg.
`timescale 1ns / 1ps

// Takes one ring byte per cycle (i_in_valid / o_in_stall) and gives at most
// one result a byte, registered as the byte is accepted; sustained rate is one
// byte per clock unless stalled. All per-byte work sits between the state
// registers and a single output register, backed by a one-entry skid register
// so the input keeps flowing while a result waits; o_in_stall rises only when
// the skid entry is occupied. The next read position (entry start + 4 + padded
// body, modulo RING_BYTES) is reduced over the first two body bytes with one
// reciprocal multiply and one constant multiply, each registered. Configure
// through the APB port only while idle; there is no clearing pass after reset.
module nic_receive_ring_deframer_top #(
    parameter int unsigned RING_BYTES = nrrd_pkg::RING_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nrrd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nrrd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nrrd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Input items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_ring_byte,
    input  logic                              i_restart,
    // Result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_kind,
    output logic [7:0]                        o_data_byte,
    output logic                              o_last_byte,
    output logic [15:0]                       o_entry_status,
    output logic [15:0]                       o_frame_length,
    output logic [15:0]                       o_release_pointer
);

    // Modulo reduction constants: sum < 2^18, q_est = floor(sum * M / 2^30)
    // is the true quotient or one below it.
    localparam int unsigned SUM_W   = 18;
    localparam int unsigned SHIFT_S = 30;
    localparam int unsigned Q_W     = 2 * SUM_W - SHIFT_S;
    localparam logic [16:0]      RingW  = 17'(RING_BYTES);
    localparam logic [SUM_W-1:0] RecipM = SUM_W'((64'd1 << SHIFT_S) / RING_BYTES);

    // Configuration registers
    logic [15:0] r_min_len, r_max_len, r_accept, r_reject, r_bias;

    // Parser state
    logic [1:0]  r_phase,  n_phase;
    logic [15:0] r_off,    n_off;
    logic [15:0] r_status, n_status;
    logic [15:0] r_len,    n_len;
    logic [15:0] r_pos,    n_pos;
    logic        r_good,   n_good;
    // Per-entry derived values, loaded at header end
    logic [15:0] r_last_idx, n_last_idx;
    logic [15:0] r_plen,     n_plen;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [Q_W-1:0]   r_quot, n_quot;
    logic [15:0]      r_next_pos, n_next_pos;

    // Output and skid stages
    logic             r_ovalid, r_svalid;
    nrrd_pkg::t_result r_out, r_skid;

    // Combinational working signals
    logic        in_acc;
    logic [1:0]  e_phase;
    logic [15:0] e_off, e_status, e_len, e_pos;
    logic [15:0] hdr_status, hdr_len, hdr_plen;
    logic        hdr_bad, hdr_good;
    logic [16:0] pos_plus4, zero_len_pos, hdr_body;
    logic [35:0] w_prod;
    logic [22:0] w_qr;
    logic [SUM_W-1:0] w_rem, w_red;
    logic        res_valid;
    nrrd_pkg::t_result res;
    logic        out_free;
    logic        cfg_wr;

    assign in_acc     = i_in_valid && !r_svalid;
    assign o_in_stall = r_svalid;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= nrrd_pkg::RST_MIN_LEN;
            r_max_len <= nrrd_pkg::RST_MAX_LEN;
            r_accept  <= nrrd_pkg::RST_ACCEPT;
            r_reject  <= nrrd_pkg::RST_REJECT;
            r_bias    <= nrrd_pkg::RST_BIAS;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                nrrd_pkg::REG_MIN_LEN: r_min_len <= pwdata[15:0];
                nrrd_pkg::REG_MAX_LEN: r_max_len <= pwdata[15:0];
                nrrd_pkg::REG_ACCEPT:  r_accept  <= pwdata[15:0];
                nrrd_pkg::REG_REJECT:  r_reject  <= pwdata[15:0];
                nrrd_pkg::REG_BIAS:    r_bias    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[4:2])
            nrrd_pkg::REG_MIN_LEN: prdata = {16'h0000, r_min_len};
            nrrd_pkg::REG_MAX_LEN: prdata = {16'h0000, r_max_len};
            nrrd_pkg::REG_ACCEPT:  prdata = {16'h0000, r_accept};
            nrrd_pkg::REG_REJECT:  prdata = {16'h0000, r_reject};
            nrrd_pkg::REG_BIAS:    prdata = {16'h0000, r_bias};
            default:               prdata = '0;
        endcase
    end

    // ---------------- header field capture ----------------
    // Restart makes this byte header byte 0 of a fresh ring.
    assign e_phase  = i_restart ? nrrd_pkg::PH_HEADER : r_phase;
    assign e_off    = i_restart ? 16'd0 : r_off;
    assign e_status = i_restart ? 16'd0 : r_status;
    assign e_len    = i_restart ? 16'd0 : r_len;
    assign e_pos    = i_restart ? 16'd0 : r_pos;

    always_comb begin
        hdr_status = e_status;
        hdr_len    = e_len;
        unique case (e_off[1:0])
            2'd0: hdr_status = {8'h00, i_ring_byte};
            2'd1: hdr_status = {i_ring_byte, e_status[7:0]};
            2'd2: hdr_len    = {8'h00, i_ring_byte};
            2'd3: hdr_len    = {i_ring_byte, e_len[7:0]};
            default: ;
        endcase
    end

    assign hdr_bad  = (hdr_len < r_min_len) || (hdr_len > r_max_len);
    assign hdr_good = (|(hdr_status & r_accept)) && !(|(hdr_status & r_reject));
    assign hdr_plen = (hdr_len >= 16'd4) ? (hdr_len - 16'd4) : 16'd0;
    assign hdr_body = ({1'b0, hdr_len} + 17'd3) & ~17'd3;

    // Zero-length entry: next position is start + 4, one wrap at most
    assign pos_plus4    = {1'b0, e_pos} + 17'd4;
    assign zero_len_pos = (pos_plus4 >= RingW) ? (pos_plus4 - RingW) : pos_plus4;

    // ---------------- next position reduction ----------------
    assign w_prod = 36'(r_sum) * 36'(RecipM);
    assign w_qr   = 23'(r_quot) * 23'(RingW);
    assign w_rem  = r_sum - w_qr[SUM_W-1:0];
    assign w_red  = (w_rem >= SUM_W'(RingW)) ? (w_rem - SUM_W'(RingW)) : w_rem;

    // ---------------- per-item next state and result ----------------
    always_comb begin
        n_phase    = r_phase;
        n_off      = r_off;
        n_status   = r_status;
        n_len      = r_len;
        n_pos      = r_pos;
        n_good     = r_good;
        n_last_idx = r_last_idx;
        n_plen     = r_plen;
        n_sum      = r_sum;
        n_quot     = r_quot;
        n_next_pos = r_next_pos;
        res_valid  = 1'b0;
        res        = '0;

        if (in_acc) begin
            if (i_restart) begin
                n_phase  = nrrd_pkg::PH_HEADER;
                n_off    = 16'd0;
                n_status = 16'd0;
                n_len    = 16'd0;
                n_pos    = 16'd0;
                n_good   = 1'b0;
            end
            unique case (e_phase)
                nrrd_pkg::PH_HEADER: begin
                    n_status = hdr_status;
                    n_len    = hdr_len;
                    if (e_off[1:0] != 2'd3) begin
                        n_off = e_off + 16'd1;
                    end else if (hdr_bad) begin
                        // Corrupt length: park until restart
                        n_phase   = nrrd_pkg::PH_CORRUPT;
                        n_off     = 16'd0;
                        n_pos     = 16'd0;
                        res_valid = 1'b1;
                        res.kind  = nrrd_pkg::KIND_CORRUPT;
                        res.entry_status    = hdr_status;
                        res.release_pointer = 16'd0 - r_bias;
                    end else begin
                        n_good     = hdr_good;
                        n_off      = 16'd0;
                        n_plen     = hdr_plen;
                        n_last_idx = 16'(hdr_body - 17'd1);
                        n_sum      = SUM_W'(e_pos) + SUM_W'(4) + SUM_W'(hdr_body);
                        if (hdr_len == 16'd0) begin
                            // Empty entry ends on its last header byte
                            n_phase   = nrrd_pkg::PH_HEADER;
                            n_pos     = zero_len_pos[15:0];
                            res_valid = 1'b1;
                            res.kind  = hdr_good ? nrrd_pkg::KIND_ACCEPT
                                                 : nrrd_pkg::KIND_DROP;
                            res.entry_status    = hdr_status;
                            res.release_pointer = zero_len_pos[15:0] - r_bias;
                        end else begin
                            n_phase = nrrd_pkg::PH_BODY;
                        end
                    end
                end
                nrrd_pkg::PH_BODY: begin
                    if (r_off >= r_last_idx) begin
                        // Final padded byte: release the entry
                        n_phase   = nrrd_pkg::PH_HEADER;
                        n_off     = 16'd0;
                        n_pos     = r_next_pos;
                        res_valid = 1'b1;
                        res.kind  = r_good ? nrrd_pkg::KIND_ACCEPT : nrrd_pkg::KIND_DROP;
                        res.entry_status    = r_status;
                        res.frame_length    = r_plen;
                        res.release_pointer = r_next_pos - r_bias;
                    end else begin
                        n_off = r_off + 16'd1;
                        // Two-step modulo over the first body bytes
                        if (r_off == 16'd0) begin
                            n_quot = w_prod[35:SHIFT_S];
                        end
                        if (r_off == 16'd1) begin
                            n_next_pos = w_red[15:0];
                        end
                        if (r_good && (r_off < r_plen)) begin
                            res_valid = 1'b1;
                            res.kind  = nrrd_pkg::KIND_PAYLOAD;
                            res.data_byte    = i_ring_byte;
                            res.last_byte    = (r_off + 16'd1 == r_plen);
                            res.entry_status = r_status;
                            res.frame_length = r_plen;
                        end
                    end
                end
                default: ;   // corrupt phase and unused code discard bytes
            endcase
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= nrrd_pkg::PH_HEADER;
            r_off    <= 16'd0;
            r_status <= 16'd0;
            r_len    <= 16'd0;
            r_pos    <= 16'd0;
            r_good   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_status <= n_status;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_good   <= n_good;
        end
    end

    // Per-entry values
    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
        r_plen     <= n_plen;
        r_sum      <= n_sum;
        r_quot     <= n_quot;
        r_next_pos <= n_next_pos;
    end

    // ---------------- output register and skid ----------------
    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= r_svalid || res_valid;
            r_svalid <= 1'b0;
        end else if (res_valid) begin
            r_svalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_svalid ? r_skid : res;
        end
        if (!out_free && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_kind            = r_out.kind;
    assign o_data_byte       = r_out.data_byte;
    assign o_last_byte       = r_out.last_byte;
    assign o_entry_status    = r_out.entry_status;
    assign o_frame_length    = r_out.frame_length;
    assign o_release_pointer = r_out.release_pointer;

`ifndef NO_ASSERTIONS
    // A skid entry only exists behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_svalid |-> r_ovalid)
        else $error("skid entry without output entry");

    // Body phase always has at least four padded bytes
    a_body_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == nrrd_pkg::PH_BODY) |-> (r_last_idx >= 16'd3))
        else $error("body entered with short padded length");

    // Reduced next position is inside the ring once it is used
    a_next_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == nrrd_pkg::PH_BODY && r_off >= 16'd2) |->
            ({1'b0, r_next_pos} < RingW))
        else $error("next read position outside ring");

    // Payload items never carry a release pointer and always carry a nonzero frame length
    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.kind == nrrd_pkg::KIND_PAYLOAD) |->
            (r_out.release_pointer == 16'd0 && r_out.frame_length != 16'd0))
        else $error("payload item with bad fields");

    // Nothing leaves the parser while parked on a corrupt entry
    a_corrupt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == nrrd_pkg::PH_CORRUPT && !i_restart) |-> !res_valid)
        else $error("result produced in corrupt phase");
`endif

endmodule
